// File: design/ordered_list_engine_macros.svh
// assertion macros for the ordered list engine
`ifndef ORDERED_LIST_ENGINE_MACROS_SVH
`define ORDERED_LIST_ENGINE_MACROS_SVH

// antecedent holds in the same cycle as the consequent
`define OLE_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define OLE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: design/ole_pkg.sv
// types and constants shared by the ordered list engine
`default_nettype none

package ole_pkg;

  localparam int OP_W    = 3;
  localparam int POS_W   = 5;
  localparam int ITEM_W  = 32;
  localparam int FOUND_W = 4;
  localparam int LEN_W   = 5;

  localparam logic [OP_W-1:0] OP_APPEND = 3'd0;
  localparam logic [OP_W-1:0] OP_INSERT = 3'd1;
  localparam logic [OP_W-1:0] OP_GET    = 3'd2;
  localparam logic [OP_W-1:0] OP_SEARCH = 3'd3;
  localparam logic [OP_W-1:0] OP_REMOVE = 3'd4;
  localparam logic [OP_W-1:0] OP_CLEAR  = 3'd5;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [POS_W-1:0]  position;
    logic [ITEM_W-1:0] item;
  } cmd_t;

  typedef struct packed {
    logic               success;
    logic [ITEM_W-1:0]  data_out;
    logic [FOUND_W-1:0] found_position;
    logic [LEN_W-1:0]   length;
  } rsp_t;

  typedef struct packed {
    logic load;
    logic take_left;
    logic take_right;
  } cell_ctrl_t;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

endpackage

`default_nettype wire

// File: design/ordered_list_engine.sv
// top level of the ordered list engine: command register, cell row and result register
//
// Command port: a word (op, position, item) is taken at a rising edge with start
// high and busy low. Ops are append, insert at position, get, search, remove at
// position and clear.
// Result port: done is high for exactly one cycle and rsp then carries success,
// data_out, found_position and length. The receiver cannot hold results off.
// Sequence: the command is registered at the command edge and executed in the
// execute state; the result is registered at its end. busy is high for the one
// execute cycle; a new word can be taken in the cycle that done is high.
// Each cell loads the key or shifts from its left or right neighbour in the
// execute cycle, and compares against the key in parallel; the lowest live
// match and the read entry are picked from the row in that same cycle.
// Reset: the list length goes to zero, busy and done go low. Entry contents are
// not cleared; entries at or beyond the length are never reported.
`default_nettype none

module ordered_list_engine import ole_pkg::*; #(
  parameter int CAPACITY    = 16,
  parameter int ENTRY_WIDTH = 32
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  output logic      busy,
  input  wire cmd_t cmd,
  output logic      done,
  output rsp_t      rsp
);

`include "ordered_list_engine_macros.svh"

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  state_t state, state_next;
  cmd_t   cmd_q;
  logic [CNT_W-1:0] cnt, cnt_next;
  rsp_t   rsp_next;

  logic [ENTRY_WIDTH-1:0] key;
  logic [ENTRY_WIDTH-1:0] entries [CAPACITY];
  logic [CAPACITY-1:0]    match;
  cell_ctrl_t             ctrl [CAPACITY];

  logic [CMP_W-1:0]       pos_x, cnt_x, found_idx;
  logic [ENTRY_WIDTH-1:0] rd_data;
  logic [ITEM_W-1:0]      rd_word;
  logic                   full, hit, exec;
  logic                   app_ok, ins_ok, rd_ok;

  generate
    if (ENTRY_WIDTH <= ITEM_W) begin : g_narrow
      assign key     = cmd_q.item[ENTRY_WIDTH-1:0];
      assign rd_word = ITEM_W'(rd_data);
    end else begin : g_wide
      assign key     = {{(ENTRY_WIDTH-ITEM_W){1'b0}}, cmd_q.item};
      assign rd_word = rd_data[ITEM_W-1:0];
    end
  endgenerate

  assign exec  = (state == ST_EXEC);
  assign busy  = exec;
  assign pos_x = CMP_W'(cmd_q.position);
  assign cnt_x = CMP_W'(cnt);
  assign full  = (cnt == CNT_W'(CAPACITY));

  assign app_ok = !full;
  assign ins_ok = !full && (pos_x <= cnt_x);
  assign rd_ok  = (pos_x < cnt_x);

  // per-cell shift and load decisions
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      ctrl[i] = '0;
      if (exec) begin
        case (cmd_q.op)
          OP_APPEND: begin
            ctrl[i].load = app_ok && (CMP_W'(i) == cnt_x);
          end
          OP_INSERT: begin
            ctrl[i].load      = ins_ok && (CMP_W'(i) == pos_x);
            ctrl[i].take_left = ins_ok && (CMP_W'(i) > pos_x);
          end
          OP_REMOVE: begin
            ctrl[i].take_right = rd_ok && (CMP_W'(i) >= pos_x);
          end
          default: begin
            ctrl[i] = '0;
          end
        endcase
      end
    end
  end

  generate
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      logic [ENTRY_WIDTH-1:0] left_in, right_in;
      if (g == 0) begin : g_first
        assign left_in = entries[g];
      end else begin : g_mid_l
        assign left_in = entries[g-1];
      end
      if (g == CAPACITY - 1) begin : g_last
        assign right_in = entries[g];
      end else begin : g_mid_r
        assign right_in = entries[g+1];
      end
      ole_cell #(
        .ENTRY_WIDTH(ENTRY_WIDTH)
      ) u_cell (
        .clk   (clk),
        .ctrl  (ctrl[g]),
        .key   (key),
        .left  (left_in),
        .right (right_in),
        .entry (entries[g]),
        .match (match[g])
      );
    end
  endgenerate

  // read select and lowest live match
  always_comb begin
    rd_data   = '0;
    found_idx = '0;
    hit       = 1'b0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (CMP_W'(i) == pos_x) begin
        rd_data = rd_data | entries[i];
      end
    end
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (match[i] && (CMP_W'(i) < cnt_x)) begin
        found_idx = CMP_W'(i);
        hit       = 1'b1;
      end
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    rsp_next   = '0;
    case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_next = ST_IDLE;
        case (cmd_q.op)
          OP_APPEND: begin
            rsp_next.success = app_ok;
            if (app_ok) begin
              cnt_next = cnt + CNT_W'(1);
            end
          end
          OP_INSERT: begin
            rsp_next.success = ins_ok;
            if (ins_ok) begin
              cnt_next = cnt + CNT_W'(1);
            end
          end
          OP_GET: begin
            rsp_next.success = rd_ok;
            if (rd_ok) begin
              rsp_next.data_out = rd_word;
            end
          end
          OP_SEARCH: begin
            rsp_next.success = hit;
            if (hit) begin
              rsp_next.found_position = found_idx[FOUND_W-1:0];
            end
          end
          OP_REMOVE: begin
            rsp_next.success = rd_ok;
            if (rd_ok) begin
              rsp_next.data_out = rd_word;
              cnt_next          = cnt - CNT_W'(1);
            end
          end
          OP_CLEAR: begin
            rsp_next.success = 1'b1;
            cnt_next         = '0;
          end
          default: begin
            rsp_next.success = 1'b0;
          end
        endcase
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
    rsp_next.length = LEN_W'(cnt_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      done  <= exec;
    end
  end

  always_ff @(posedge clk) begin
    if (!exec && start) begin
      cmd_q <= cmd;
    end
    if (exec) begin
      rsp <= rsp_next;
    end
  end

  `OLE_ASSERT_NEXT(a_exec_gives_result, busy, done, "execute cycle not followed by a result")
  `OLE_ASSERT_SAME(a_result_not_busy, done, !busy, "result strobe while executing")
  `OLE_ASSERT_SAME(a_count_bound, 1'b1, cnt <= CNT_W'(CAPACITY), "length above capacity")
  `OLE_ASSERT_SAME(a_fail_zero, done && !rsp.success, (rsp.data_out == '0) && (rsp.found_position == '0), "failed result carries data")

endmodule

`default_nettype wire

// File: design/ole_cell.sv
// one list cell: holds an entry, shifts from a neighbour, compares against the key
`default_nettype none

module ole_cell import ole_pkg::*; #(
  parameter int ENTRY_WIDTH = 32
) (
  input  wire logic                   clk,
  input  wire cell_ctrl_t             ctrl,
  input  wire logic [ENTRY_WIDTH-1:0] key,
  input  wire logic [ENTRY_WIDTH-1:0] left,
  input  wire logic [ENTRY_WIDTH-1:0] right,
  output logic      [ENTRY_WIDTH-1:0] entry,
  output logic                        match
);

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      entry <= key;
    end else if (ctrl.take_left) begin
      entry <= left;
    end else if (ctrl.take_right) begin
      entry <= right;
    end
  end

  assign match = (entry == key);

endmodule

`default_nettype wire

// File: tb/ordered_list_engine_tb.sv
`timescale 1ns / 100ps
// self-checking testbench for the ordered list engine: directed edge cases then random words
module ordered_list_engine_tb;
  import ole_pkg::*;

  localparam int DEPTH        = 16;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 6;
  localparam int REPORT_MAX   = 10;

  localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

  logic clk   = 1'b0;
  logic rst   = 1'b1;
  logic start = 1'b0;
  cmd_t cmd   = '0;
  logic busy;
  logic done;
  rsp_t rsp;

  bit [ITEM_W-1:0] list_mem [DEPTH];
  int list_len = 0;
  bit filling = 1'b1;
  rsp_t awaited_rsp [$];
  int fail_count = 0;
  int cycle_count = 0;
  int idle_pct = 0;

  ordered_list_engine i_dut (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .busy (busy),
    .cmd  (cmd),
    .done (done),
    .rsp  (rsp)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // list behaviour: updates the shadow list and gives the word the engine should return
  function automatic rsp_t predict_list_op(cmd_t c);
    rsp_t r;
    int i;
    r = '0;
    case (c.op)
      OP_APPEND: begin
        if (list_len < DEPTH) begin
          list_mem[list_len] = c.item;
          list_len++;
          r.success = 1'b1;
        end
      end
      OP_INSERT: begin
        if (list_len < DEPTH && c.position <= list_len) begin
          for (i = list_len; i > c.position; i--)
            list_mem[i] = list_mem[i-1];
          list_mem[c.position] = c.item;
          list_len++;
          r.success = 1'b1;
        end
      end
      OP_GET: begin
        if (c.position < list_len) begin
          r.data_out = list_mem[c.position];
          r.success  = 1'b1;
        end
      end
      OP_SEARCH: begin
        for (i = 0; i < list_len; i++) begin
          if (!r.success && list_mem[i] == c.item) begin
            r.success        = 1'b1;
            r.found_position = i[FOUND_W-1:0];
          end
        end
      end
      OP_REMOVE: begin
        if (c.position < list_len) begin
          r.data_out = list_mem[c.position];
          for (i = c.position + 1; i < list_len; i++)
            list_mem[i-1] = list_mem[i];
          list_len--;
          r.success = 1'b1;
        end
      end
      OP_CLEAR: begin
        list_len  = 0;
        r.success = 1'b1;
      end
      default: ;
    endcase
    r.length = list_len[LEN_W-1:0];
    return r;
  endfunction

  function automatic cmd_t list_word(logic [OP_W-1:0] op, logic [POS_W-1:0] position,
                                     logic [ITEM_W-1:0] item);
    cmd_t c;
    c.op       = op;
    c.position = position;
    c.item     = item;
    return c;
  endfunction

  // mostly well-formed traffic that sweeps the list between empty and full
  function automatic cmd_t random_list_cmd();
    cmd_t c;
    int pick;
    int grow;
    int v;
    if (list_len == DEPTH)
      filling = 1'b0;
    else if (list_len == 0)
      filling = 1'b1;
    else if ($urandom_range(99) < 2)
      filling = ~filling;
    grow = filling ? 45 : 10;
    pick = $urandom_range(99);
    if (pick < 3)
      c.op = $urandom_range(1) ? OP_SPARE_HI : OP_SPARE_LO;
    else if (pick < 5)
      c.op = OP_CLEAR;
    else if (pick < 5 + grow)
      c.op = $urandom_range(1) ? OP_APPEND : OP_INSERT;
    else if (pick < 5 + grow + 20)
      c.op = $urandom_range(1) ? OP_GET : OP_SEARCH;
    else
      c.op = OP_REMOVE;

    v = $urandom_range(99);
    if (v < 8)
      c.position = POS_W'($urandom_range(31));
    else if (v < 18)
      c.position = list_len[POS_W-1:0];
    else if (c.op == OP_INSERT)
      c.position = POS_W'($urandom_range(list_len));
    else
      c.position = POS_W'($urandom_range(list_len > 0 ? list_len - 1 : 0));

    v = $urandom_range(99);
    if (c.op == OP_SEARCH && list_len > 0 && v < 60)
      c.item = list_mem[$urandom_range(list_len - 1)];
    else if (v < 30)
      c.item = $urandom_range(3);
    else if (v < 36)
      c.item = '1;
    else if (v < 40)
      c.item = '0;
    else
      c.item = $urandom;
    return c;
  endfunction

  task automatic send_word(cmd_t c);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    cmd   <= c;
    do @(posedge clk); while (busy);
    awaited_rsp.push_back(predict_list_op(c));
  endtask

  task automatic run_random_words(int n);
    cmd_t c;
    int sent;
    sent = 0;
    while (sent < n) begin
      c = random_list_cmd();
      send_word(c);
      if (c.op <= OP_CLEAR)
        sent++;
    end
  endtask

  task automatic note_failure(string msg);
    fail_count++;
    if (fail_count <= REPORT_MAX)
      $display("mismatch at %0t: %s", $realtime, msg);
  endtask

  always @(posedge clk) begin : rsp_check
    rsp_t want;
    if (!rst && done) begin
      if (awaited_rsp.size() == 0) begin
        note_failure($sformatf("result word with nothing outstanding: %p", rsp));
      end else begin
        want = awaited_rsp.pop_front();
        if (rsp.success !== want.success)
          note_failure($sformatf("success exp %0b got %0b", want.success, rsp.success));
        if (rsp.data_out !== want.data_out)
          note_failure($sformatf("data_out exp %h got %h", want.data_out, rsp.data_out));
        if (rsp.found_position !== want.found_position)
          note_failure($sformatf("found_position exp %0d got %0d",
                                 want.found_position, rsp.found_position));
        if (rsp.length !== want.length)
          note_failure($sformatf("length exp %0d got %0d", want.length, rsp.length));
      end
    end
  end

  task automatic test_directed_cases();
    int i;
    send_word(list_word(OP_REMOVE, 5'd31, 32'h0));
    send_word(list_word(OP_SEARCH, 5'd0, 32'h0));
    send_word(list_word(OP_INSERT, 5'd1, 32'h1234_5678));
    send_word(list_word(OP_SPARE_LO, 5'd0, 32'hFFFF_FFFF));
    send_word(list_word(OP_SPARE_HI, 5'd31, 32'h5555_5555));
    send_word(list_word(OP_INSERT, 5'd0, 32'hFFFF_FFFF));
    send_word(list_word(OP_INSERT, 5'd1, 32'h0000_0000));
    send_word(list_word(OP_INSERT, 5'd1, 32'h8000_0001));
    for (i = 0; i < DEPTH - 3; i++)
      send_word(list_word(OP_APPEND, 5'd0, (i % 4 == 3) ? 32'h5A5A_5A5A : ITEM_W'(i)));
    send_word(list_word(OP_APPEND, 5'd0, 32'hAAAA_AAAA));
    send_word(list_word(OP_INSERT, 5'd0, 32'hAAAA_AAAA));
    send_word(list_word(OP_GET, 5'd15, 32'h0));
    send_word(list_word(OP_GET, 5'd16, 32'h0));
    send_word(list_word(OP_SEARCH, 5'd0, 32'h5A5A_5A5A));
    send_word(list_word(OP_REMOVE, 5'd0, 32'h0));
    send_word(list_word(OP_CLEAR, 5'd0, 32'h0));
  endtask

  task automatic test_random_sparse_gaps();
    idle_pct = 18;
    run_random_words(580);
  endtask

  task automatic test_random_dense_gaps();
    idle_pct = 63;
    run_random_words(580);
  endtask

  task automatic test_random_back_to_back();
    idle_pct = 0;
    run_random_words(590);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_directed_cases();
    test_random_sparse_gaps();
    test_random_dense_gaps();
    test_random_back_to_back();
    start <= 1'b0;
    while (awaited_rsp.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
